// ===== rtl/mtg_pkg.sv =====
`timescale 1ns / 1ps
package mtg_pkg;
  localparam int STATE_WORDS   = 624;
  localparam int MIDDLE_OFFSET = 397;
  localparam int KEY_DEPTH     = 624;
  localparam int SW            = 10;
  localparam int KW            = 10;
  localparam int KFW           = 10;

  localparam logic [31:0] MIX_MATRIX  = 32'h9908b0df;
  localparam logic [31:0] INIT_MULT   = 32'd1812433253;
  localparam logic [31:0] KEY_SEED    = 32'd19650218;
  localparam logic [31:0] MIX1_MULT   = 32'd1664525;
  localparam logic [31:0] MIX2_MULT   = 32'd1566083941;
  localparam logic [31:0] RESET_SEED  = 32'd5489;
  localparam logic [31:0] WORD0_FORCE = 32'h80000000;

  typedef enum logic [1:0] {
    ACT_READ = 2'd0,
    ACT_SEED = 2'd1,
    ACT_KEY  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [3:0] {
    ST_SCALAR, ST_IDLE, ST_TW_RD, ST_TW_WR, ST_RD_WAIT, ST_RD_OUT,
    ST_M1_RD, ST_M1_WR, ST_M2_RD, ST_M2_WR, ST_W0_RD, ST_W0_WR, ST_FORCE
  } state_t;

  function automatic logic [31:0] temper(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9d2c5680);
    y = y ^ ((y << 15) & 32'hefc60000);
    return y ^ (y >> 18);
  endfunction

  function automatic logic [31:0] mixp(input logic [31:0] p);
    return p ^ (p >> 30);
  endfunction
endpackage

// ===== rtl/mersenne_twister_generator.sv =====
`timescale 1ns / 1ps
// Channel  Dir  Word contents (lowest bit first)
// in_      in   tdata[31:0] data_word, tuser[1:0] action, tlast key_last
// out_     out  tdata[31:0] random_word
// A read runs a word twist in ST_TW_RD (three state reads, one write), then ST_TW_WR,
// where the write settles and the memory read is issued, then ST_RD_OUT; the whole state
// is twisted lazily, one word per read. A new read is accepted only once the block is idle
// and the last result has been taken. Scalar seeding writes one word a cycle; key seeding
// adds two read-modify-write passes over the state words.
// After reset the block seeds 5489 and accepts nothing meanwhile.
// A waiting result blocks new input until out_tready takes it.
module mersenne_twister_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // data_word
  input  logic [1:0]  in_tuser,   // action
  input  logic        in_tlast,   // key_last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // random_word
);
  import mtg_pkg::*;

  state_t state_r, state_nxt;
  logic [SW-1:0]  pos_r, pos_nxt;     // read position, STATE_WORDS forces twist
  logic [SW-1:0]  twc_r, twc_nxt;     // next word index to twist
  logic [SW-1:0]  i_r, i_nxt;
  logic [KW-1:0]  j_r, j_nxt;
  logic [KFW:0]   k_r, k_nxt;         // pass step count
  logic [KFW-1:0] fill_r, fill_nxt;
  logic [KFW-1:0] len_r, len_nxt;
  logic [31:0]    prev_r, prev_nxt;   // previous word written
  logic [31:0]    a_r, a_nxt, b_r, b_nxt;
  logic [1:0]     ph_r, ph_nxt;       // read phase within a twist
  logic           pend_r, pend_nxt;   // key seeding queued after scalar pass
  logic [31:0]    out_r, out_nxt;
  logic           ov_r, ov_nxt;

  logic          s_we;
  logic [SW-1:0] s_wa, s_ra;
  logic [31:0]   s_wd, s_rd;
  logic          k_we;
  logic [KW-1:0] k_wa, k_ra;
  logic [31:0]   k_wd, k_rd;
  logic [31:0]   ytw, prod;
  logic          acc;

  mtg_ram #(.WIDTH(32), .DEPTH(STATE_WORDS)) u_state (
    .clk(clk), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
    .rd_addr(s_ra), .rd_data(s_rd));
  mtg_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH)) u_key (
    .clk(clk), .wr_en(k_we), .wr_addr(k_wa), .wr_data(k_wd),
    .rd_addr(k_ra), .rd_data(k_rd));

  assign in_tready  = (state_r == ST_IDLE) && !ov_r;
  assign acc        = in_tvalid && in_tready;
  assign out_tvalid = ov_r;
  assign out_tdata  = out_r;

  // Modular neighbour indices of the twist.
  function automatic logic [SW-1:0] wrap(input logic [SW:0] x);
    return (x >= (SW+1)'(STATE_WORDS)) ? SW'(x - (SW+1)'(STATE_WORDS)) : x[SW-1:0];
  endfunction

  assign ytw = (a_r & WORD0_FORCE) | (b_r & ~WORD0_FORCE);

  // Registered control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SCALAR;
      pos_r   <= SW'(STATE_WORDS);
      fill_r  <= '0;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
      i_r     <= '0;
      prev_r  <= RESET_SEED;
      twc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      fill_r  <= fill_nxt;
      ov_r    <= ov_nxt;
      pend_r  <= pend_nxt;
      i_r     <= i_nxt;
      prev_r  <= prev_nxt;
      twc_r   <= twc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    len_r <= len_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    ph_r  <= ph_nxt;
    out_r <= out_nxt;
  end

  // Sequencer for reads, twists and seeding passes.
  always_comb begin
    state_nxt = state_r;
    pos_nxt = pos_r; twc_nxt = twc_r; i_nxt = i_r; j_nxt = j_r; k_nxt = k_r;
    fill_nxt = fill_r; len_nxt = len_r; prev_nxt = prev_r;
    a_nxt = a_r; b_nxt = b_r; ph_nxt = ph_r; pend_nxt = pend_r;
    out_nxt = out_r; ov_nxt = ov_r;
    s_we = 1'b0; s_wa = i_r; s_wd = '0; s_ra = i_r;
    k_we = 1'b0; k_wa = fill_r[KW-1:0]; k_wd = in_tdata; k_ra = j_r;
    prod = '0;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      // Scalar recurrence, one word each cycle.
      ST_SCALAR: begin
        if (i_r == '0) begin
          s_we = 1'b1; s_wa = '0; s_wd = prev_r; i_nxt = SW'(1);
        end else begin
          prod = INIT_MULT * mixp(prev_r);
          s_we = 1'b1; s_wa = i_r; s_wd = prod + 32'(i_r);
          prev_nxt = s_wd;
          if (i_r == SW'(STATE_WORDS - 1)) begin
            pos_nxt = SW'(STATE_WORDS);
            twc_nxt = '0;
            if (pend_r) begin
              // The first mixing step starts from word 0, the key seed.
              pend_nxt = 1'b0; i_nxt = SW'(1); j_nxt = '0; prev_nxt = KEY_SEED;
              k_nxt = (len_r > KFW'(STATE_WORDS)) ? (KFW+1)'(len_r)
                                                   : (KFW+1)'(STATE_WORDS);
              state_nxt = ST_M1_RD;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            i_nxt = i_r + SW'(1);
          end
        end
      end
      ST_IDLE: begin
        if (acc) begin
          case (action_t'(in_tuser))
            ACT_READ: begin
              ph_nxt = '0;
              if (pos_r == SW'(STATE_WORDS)) begin
                pos_nxt = '0;
              end
              // Twist the word about to be read unless already twisted.
              if (pos_r == SW'(STATE_WORDS) || pos_r == twc_r) begin
                if (pos_r == SW'(STATE_WORDS)) twc_nxt = '0;
                state_nxt = ST_TW_RD;
              end else begin
                state_nxt = ST_RD_WAIT;
              end
            end
            ACT_SEED: begin
              prev_nxt = in_tdata; i_nxt = '0; state_nxt = ST_SCALAR;
            end
            ACT_KEY: begin
              if (fill_r < KFW'(KEY_DEPTH)) begin
                k_we = 1'b1; fill_nxt = fill_r + KFW'(1);
              end
              if (in_tlast) begin
                len_nxt = (fill_r < KFW'(KEY_DEPTH)) ? fill_r + KFW'(1) : fill_r;
                fill_nxt = '0; pend_nxt = 1'b1;
                prev_nxt = KEY_SEED; i_nxt = '0; state_nxt = ST_SCALAR;
              end
            end
            default: ;
          endcase
        end
      end
      // Read words n, n+1 and n+397 in turn; each word's data is taken in the phase after its address.
      ST_TW_RD: begin
        ph_nxt = ph_r + 2'd1;
        case (ph_r)
          2'd0: s_ra = twc_r;
          2'd1: begin s_ra = wrap((SW+1)'(twc_r) + (SW+1)'(1)); a_nxt = s_rd; end
          2'd2: begin
            s_ra = wrap((SW+1)'(twc_r) + (SW+1)'(MIDDLE_OFFSET)); b_nxt = s_rd;
          end
          default: begin
            s_ra = twc_r;
            s_we = 1'b1; s_wa = twc_r;
            s_wd = s_rd ^ (ytw >> 1) ^ (b_r[0] ? MIX_MATRIX : 32'd0);
            twc_nxt = (twc_r == SW'(STATE_WORDS - 1)) ? SW'(STATE_WORDS) : twc_r + SW'(1);
            state_nxt = ST_TW_WR;
          end
        endcase
      end
      ST_TW_WR: begin
        s_ra = pos_r; state_nxt = ST_RD_OUT;
      end
      ST_RD_WAIT: begin
        s_ra = pos_r; state_nxt = ST_RD_OUT;
      end
      ST_RD_OUT: begin
        out_nxt = temper(s_rd); ov_nxt = 1'b1;
        pos_nxt = pos_r + SW'(1);
        state_nxt = ST_IDLE;
      end
      // First mixing pass: read word i, prev_r already holds word i-1.
      ST_M1_RD: begin
        s_ra = i_r; k_ra = j_r; state_nxt = ST_M1_WR;
        prod = MIX1_MULT * mixp(prev_r);
        a_nxt = prod;
      end
      ST_M1_WR: begin
        s_we = 1'b1; s_wa = i_r;
        s_wd = (s_rd ^ a_r) + k_rd + 32'(j_r);
        prev_nxt = s_wd;
        j_nxt = (KFW'(j_r) + KFW'(1) >= len_r) ? '0 : j_r + KW'(1);
        k_nxt = k_r - (KFW+1)'(1);
        if (i_r == SW'(STATE_WORDS - 1)) begin
          i_nxt = SW'(1);
          ph_nxt = 2'd0;
          state_nxt = ST_W0_WR;
        end else begin
          i_nxt = i_r + SW'(1);
          state_nxt = (k_r == (KFW+1)'(1)) ? ST_M2_RD : ST_M1_RD;
          if (k_r == (KFW+1)'(1)) k_nxt = (KFW+1)'(STATE_WORDS - 1);
        end
      end
      // Copy last word to word 0; ph_r says which pass resumes.
      ST_W0_WR: begin
        s_we = 1'b1; s_wa = '0; s_wd = prev_r;
        if (ph_r == 2'd0) begin
          if (k_r == '0) begin
            k_nxt = (KFW+1)'(STATE_WORDS - 1); state_nxt = ST_M2_RD;
          end else begin
            state_nxt = ST_M1_RD;
          end
        end else begin
          state_nxt = (k_r == '0) ? ST_FORCE : ST_M2_RD;
        end
      end
      ST_M2_RD: begin
        s_ra = i_r; state_nxt = ST_M2_WR;
        prod = MIX2_MULT * mixp(prev_r);
        a_nxt = prod;
      end
      ST_M2_WR: begin
        s_we = 1'b1; s_wa = i_r;
        s_wd = (s_rd ^ a_r) - 32'(i_r);
        prev_nxt = s_wd;
        k_nxt = k_r - (KFW+1)'(1);
        if (i_r == SW'(STATE_WORDS - 1)) begin
          i_nxt = SW'(1); ph_nxt = 2'd1; state_nxt = ST_W0_WR;
        end else begin
          i_nxt = i_r + SW'(1);
          state_nxt = (k_r == (KFW+1)'(1)) ? ST_FORCE : ST_M2_RD;
        end
      end
      ST_W0_RD: state_nxt = ST_FORCE;
      ST_FORCE: begin
        s_we = 1'b1; s_wa = '0; s_wd = WORD0_FORCE;
        pos_nxt = SW'(STATE_WORDS); twc_nxt = '0;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  // No input is taken while a result still waits.
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> !in_tready) else $error("input taken while result pending");
  // A result appears only after a read step.
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ov_r) |-> $past(state_r) == ST_RD_OUT) else $error("stray result");
  // Read position never passes the state size.
  a_pos: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= SW'(STATE_WORDS)) else $error("read position out of range");
`endif
endmodule

// ===== rtl/mtg_ram.sv =====
`timescale 1ns / 1ps
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
